/* rtl/qpv_pkg.sv */
// ----------------------------------------------------------------------------
// qpv_pkg
// Shared types, constants and helpers for the quadrature position/velocity
// block.
// ----------------------------------------------------------------------------
package qpv_pkg;

    localparam int S_TDATA_W = 40;   // pin_a, pin_b, time_us, zero pad
    localparam int S_TUSER_W = 2;    // mode
    localparam int M_TDATA_W = 96;   // position, angle, velocity
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] SCALE_RESET = 32'd13176795;
    localparam logic [16:0] ALPHA_RESET = 17'd6554;
    localparam logic [16:0] ALPHA_ONE   = 17'd65536;
    // 1e6 / 64 = 15625; the remaining 1/1024 is a shift after the divide.
    localparam logic [31:0] VEL_FACTOR  = 32'd15625;
    localparam int          DIV_STEPS   = 41;

    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_ALPHA = 1'b1;

    typedef enum logic [1:0] {
        MODE_PIN   = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_START = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Step for pin pair now given previous pair (pair = {A, B}).
    function automatic logic signed [1:0] pin_step(input logic [1:0] now_pins,
                                                   input logic [1:0] prev_pins);
        logic signed [1:0] d;
        d = 2'sd0;
        case ({now_pins, prev_pins})
            4'b00_01: d = -2'sd1;
            4'b00_10: d = 2'sd1;
            4'b01_00: d = 2'sd1;
            4'b01_11: d = -2'sd1;
            4'b10_00: d = -2'sd1;
            4'b10_11: d = 2'sd1;
            4'b11_01: d = 2'sd1;
            4'b11_10: d = -2'sd1;
            default:  d = 2'sd0;
        endcase
        return d;
    endfunction

    // Sign and magnitude to a saturated 32-bit signed value.
    function automatic logic [31:0] sat_signed(input logic neg, input logic [47:0] mag);
        logic [31:0] r;
        if (neg) begin
            if (mag >= 48'h8000_0000) begin
                r = 32'h8000_0000;
            end else begin
                r = 32'd0 - mag[31:0];
            end
        end else begin
            if (mag > 48'h7FFF_FFFF) begin
                r = 32'h7FFF_FFFF;
            end else begin
                r = mag[31:0];
            end
        end
        return r;
    endfunction

endpackage

/* rtl/quadrature_position_velocity.sv */
// ----------------------------------------------------------------------------
// quadrature_position_velocity
// Quadrature edge counter with Q16.16 angle and low-pass filtered velocity,
// built around one shared 33x33 multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel | ports              | payload
//  --------+--------------------+-------------------------------------------
//  input   | s_tvalid/s_tready  | s_tuser: mode; s_tdata: pins, time_us
//  result  | m_tvalid/m_tready  | m_tuser: velocity_updated; m_tdata: 3 words
//  config  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Pin sample, start, idle mode and a tick without velocity go from decode
//  straight to the angle multiply. A tick that recomputes velocity runs the
//  41-step restoring divider plus five multiplier passes; saturation skips the divide.
//  Reset is synchronous; the counters and filter clear, registers reload.
//  One beat in flight; a result held by m_tready stalls the next finish.
// ----------------------------------------------------------------------------
module quadrature_position_velocity (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] pin_a, [1] pin_b, [33:2] time_us, [39:34] zero
    input  logic [qpv_pkg::S_TDATA_W-1:0]       s_tdata,
    // [1:0] mode
    input  logic [qpv_pkg::S_TUSER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] position_count, [63:32] angle_q16, [95:64] velocity_q16
    output logic [qpv_pkg::M_TDATA_W-1:0]       m_tdata,
    // [0] velocity_updated
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [qpv_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import qpv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_VMUL, S_VLO, S_VHI, S_VSUM, S_VCHK, S_VDIV,
        S_BLEND, S_BACC, S_AMUL, S_ASAT, S_OUT
    } state_t;

    state_t              state_reg;
    mode_t               mode_reg;
    logic [1:0]          pins_reg;
    logic [31:0]         time_reg;

    logic [31:0]         scale_reg;
    logic [16:0]         alpha_reg;

    logic [31:0]         edge_reg;
    logic [1:0]          prev_pins_reg;
    logic [31:0]         cnt_last_reg;
    logic [31:0]         last_time_reg;
    logic [31:0]         filt_reg;

    logic [31:0]         dt_reg;
    logic [31:0]         dmag_reg;
    logic                neg_reg;
    logic [31:0]         m_hi_reg;
    logic [78:0]         num_reg;
    logic [31:0]         rem_reg;
    logic [40:0]         quo_reg;
    logic [5:0]          cnt_reg;
    logic                ovf_reg;
    logic [31:0]         angle_reg;
    logic                updated_reg;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  prod_reg;

    // decode helpers
    logic signed [1:0]   step;
    logic [31:0]         dt_now;
    logic [31:0]         diff_now;
    // divider step
    logic [32:0]         partial;
    logic [33:0]         trial;
    logic                ge;
    // filter helpers
    logic [16:0]         alpha_eff;
    logic [31:0]         inst;
    logic signed [32:0]  vdiff;
    logic signed [50:0]  acc;
    logic [50:0]         acc_mag;
    logic [34:0]         blend_mag;
    logic [31:0]         emag;
    logic [47:0]         angle_mag;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb begin
        step      = pin_step(pins_reg, prev_pins_reg);
        dt_now    = time_reg - last_time_reg;
        diff_now  = edge_reg - cnt_last_reg;

        partial   = {rem_reg, quo_reg[40]};
        trial     = {1'b0, partial} - {2'b00, dt_reg};
        ge        = !trial[33];

        alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        if (ovf_reg) begin
            inst = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (neg_reg) begin
            inst = 32'd0 - {1'b0, quo_reg[40:10]};
        end else begin
            inst = {1'b0, quo_reg[40:10]};
        end
        vdiff     = $signed({inst[31], inst}) - $signed({filt_reg[31], filt_reg});

        // filt*65536 + alpha*(inst - filt)
        acc       = $signed({{3{filt_reg[31]}}, filt_reg, 16'd0}) + prod_reg[50:0];
        acc_mag   = acc[50] ? (51'd0 - acc) : acc;
        blend_mag = 35'((acc_mag + 51'd32768) >> 16);

        emag      = edge_reg[31] ? (32'd0 - edge_reg) : edge_reg;
        angle_mag = 48'((prod_reg[63:0] + 64'd32768) >> 16);

        case (state_reg)
            S_VMUL: begin
                mul_a = $signed({1'b0, dmag_reg});
                mul_b = $signed({1'b0, scale_reg});
            end
            S_VLO: begin
                mul_a = $signed({1'b0, prod_reg[31:0]});
                mul_b = $signed({1'b0, VEL_FACTOR});
            end
            S_VHI: begin
                mul_a = $signed({1'b0, m_hi_reg});
                mul_b = $signed({1'b0, VEL_FACTOR});
            end
            S_BLEND: begin
                mul_a = $signed({16'd0, alpha_eff});
                mul_b = vdiff;
            end
            S_AMUL: begin
                mul_a = $signed({1'b0, emag});
                mul_b = $signed({1'b0, scale_reg});
            end
            default: begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            scale_reg     <= SCALE_RESET;
            alpha_reg     <= ALPHA_RESET;
            edge_reg      <= 32'd0;
            prev_pins_reg <= 2'd0;
            cnt_last_reg  <= 32'd0;
            last_time_reg <= 32'd0;
            filt_reg      <= 32'd0;
            updated_reg   <= 1'b0;
            cnt_reg       <= 6'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SCALE: scale_reg <= cfg_data;
                    CFG_ALPHA: alpha_reg <= cfg_data[16:0];
                    default:   ;
                endcase
            end

            // S_OUT reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg  <= mode_t'(s_tuser);
                        pins_reg  <= {s_tdata[0], s_tdata[1]};
                        time_reg  <= s_tdata[33:2];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    updated_reg <= 1'b0;
                    if (mode_reg == MODE_TICK && dt_now != 32'd0 &&
                        last_time_reg != 32'd0) begin
                        state_reg <= S_VMUL;
                    end else begin
                        state_reg <= S_AMUL;
                    end
                    case (mode_reg)
                        MODE_PIN: begin
                            edge_reg      <= edge_reg + {{30{step[1]}}, step};
                            prev_pins_reg <= pins_reg;
                        end
                        MODE_TICK: begin
                            dt_reg        <= dt_now;
                            neg_reg       <= diff_now[31];
                            dmag_reg      <= diff_now[31] ? (32'd0 - diff_now) : diff_now;
                            cnt_last_reg  <= edge_reg;
                            last_time_reg <= time_reg;
                        end
                        MODE_START: begin
                            prev_pins_reg <= pins_reg;
                            edge_reg      <= 32'd0;
                            cnt_last_reg  <= 32'd0;
                            last_time_reg <= time_reg;
                        end
                        default: ;
                    endcase
                end
                S_VMUL: state_reg <= S_VLO;
                S_VLO: begin
                    m_hi_reg  <= prod_reg[63:32];
                    state_reg <= S_VHI;
                end
                S_VHI: begin
                    // low partial product plus the rounding bias 512*dt
                    num_reg   <= 79'(prod_reg[45:0]) + (79'(dt_reg) << 9);
                    state_reg <= S_VSUM;
                end
                S_VSUM: begin
                    num_reg   <= num_reg + (79'(prod_reg[45:0]) << 32);
                    state_reg <= S_VCHK;
                end
                S_VCHK: begin
                    // quotient >= 2^41 saturates either way
                    ovf_reg <= (num_reg[78:41] >= {6'd0, dt_reg});
                    rem_reg <= num_reg[72:41];
                    quo_reg <= num_reg[40:0];
                    cnt_reg <= 6'(DIV_STEPS);
                    if (num_reg[78:41] >= {6'd0, dt_reg}) begin
                        state_reg <= S_BLEND;
                    end else begin
                        state_reg <= S_VDIV;
                    end
                end
                S_VDIV: begin
                    rem_reg <= ge ? trial[31:0] : partial[31:0];
                    quo_reg <= {quo_reg[39:0], ge};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        state_reg <= S_BLEND;
                    end
                end
                S_BLEND: state_reg <= S_BACC;
                S_BACC: begin
                    filt_reg    <= sat_signed(acc[50], {13'd0, blend_mag});
                    updated_reg <= 1'b1;
                    state_reg   <= S_AMUL;
                end
                S_AMUL: state_reg <= S_ASAT;
                S_ASAT: begin
                    angle_reg <= sat_signed(edge_reg[31], angle_mag);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {filt_reg, angle_reg, edge_reg};
                        m_tuser_reg  <= updated_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // the divider remainder always stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_VDIV) |-> (rem_reg < dt_reg))
        else $error("divider remainder not below dt");

    // filter state only moves at the blend step
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(filt_reg) |-> $past(state_reg == S_BACC))
        else $error("filtered velocity changed outside blend");

    // edge count only moves at decode
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(edge_reg) |-> $past(state_reg == S_DECODE))
        else $error("edge count changed outside decode");

    // one beat in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a beat while busy");

    // a velocity-updated result only follows a tick beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && updated_reg) |-> (mode_reg == MODE_TICK))
        else $error("velocity update flagged on a non-tick beat");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quadrature_position_velocity. A directed table of
// beats and register writes runs first, then randomized encoder walks, ticks
// and starts under three input/output idling mixes and several register
// settings. Every input beat is run through a local model of the edge
// counter, angle scaling and velocity filter; each result beat is compared
// against the oldest queued expectation (the model's, or a typed row's).
// ----------------------------------------------------------------------------
module tb_top;
    import qpv_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SEG_BEATS    = 158;
    localparam int LONG_HOLD    = 300;
    localparam int N_DIRECTED   = 31;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] angle;
        logic [31:0] vel;
        logic        upd;
    } quad_result_t;

    typedef struct packed {
        logic         is_cfg;
        logic         reg_sel;
        logic [31:0]  value;    // register data, or time_us for a beat
        mode_t        md;
        logic [1:0]   pins;     // {A, B}
        logic         typed;
        quad_result_t want;
    } row_t;

    localparam quad_result_t NOT_TYPED = '0;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    quadrature_position_velocity dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state and registers
    logic [31:0]        enc_count = '0;
    logic [1:0]         enc_prev_pins = '0;
    logic [31:0]        enc_tick_count = '0;
    logic [31:0]        enc_tick_time = '0;
    logic signed [31:0] enc_velocity = '0;
    logic [31:0]        cur_scale = SCALE_RESET;
    logic [16:0]        cur_alpha = ALPHA_RESET;

    quad_result_t pending_results[$];

    int  tx_idle_pct = 22;
    int  rx_idle_pct = 63;
    int  hold_reqs = 0;
    int  errors = 0;
    int  beats_sent = 0;
    int  beats_checked = 0;
    int  vel_updates = 0;
    int  reg_writes = 0;
    int  cycles = 0;
    logic [31:0] clock_us = 32'd1;

    row_t directed_rows [N_DIRECTED] = '{
        // after reset, then one full forward cycle
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b00, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b0}},
        '{1'b0, CFG_SCALE, 32'hFFFF_FFFF, MODE_PIN, 2'b01, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b11, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b10, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b00, 1'b0, NOT_TYPED},
        // both bits flip, then a reverse step
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b11, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b01, 1'b0, NOT_TYPED},
        // tick with no previous tick time, then a zero-length interval
        '{1'b0, CFG_SCALE, 32'd100, MODE_TICK, 2'b00, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b00, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd100, MODE_TICK, 2'b00, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b10, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd1100, MODE_TICK, 2'b00, 1'b0, NOT_TYPED},
        // time going backward wraps the interval
        '{1'b0, CFG_SCALE, 32'd600, MODE_TICK, 2'b00, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'hA5A5_A5A5, MODE_NONE, 2'b11, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd2000, MODE_START, 2'b11, 1'b0, NOT_TYPED},
        // largest scale, filter passes new value straight through
        '{1'b1, CFG_SCALE, 32'hFFFF_FFFF, MODE_PIN, 2'b00, 1'b0, NOT_TYPED},
        '{1'b1, CFG_ALPHA, 32'd65536, MODE_PIN, 2'b00, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd7, MODE_START, 2'b11, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b10, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd8, MODE_TICK, 2'b00, 1'b1,
          '{32'd1, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1}},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b11, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b01, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd9, MODE_TICK, 2'b00, 1'b1,
          '{32'hFFFF_FFFF, 32'hFFFF_0000, 32'h8000_0000, 1'b1}},
        // alpha beyond one clamps
        '{1'b1, CFG_ALPHA, 32'h0001_FFFF, MODE_PIN, 2'b00, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b11, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd10, MODE_TICK, 2'b00, 1'b1,
          '{32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1}},
        // alpha zero holds the filter, smallest scale
        '{1'b1, CFG_ALPHA, 32'd0, MODE_PIN, 2'b00, 1'b0, NOT_TYPED},
        '{1'b1, CFG_SCALE, 32'd1, MODE_PIN, 2'b00, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd0, MODE_PIN, 2'b10, 1'b0, NOT_TYPED},
        '{1'b0, CFG_SCALE, 32'd5000, MODE_TICK, 2'b00, 1'b1,
          '{32'd1, 32'd0, 32'h7FFF_FFFF, 1'b1}},
        '{1'b0, CFG_SCALE, 32'hFFFF_0000, MODE_NONE, 2'b00, 1'b0, NOT_TYPED}
    };

    // ---------------------------------------------------------------- model

    function automatic logic [31:0] clamp32(input logic neg, input logic [63:0] mag);
        if (neg) begin
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        end
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    // Gray phase: 00 -> 0, 01 -> 1, 11 -> 2, 10 -> 3; one phase up is +1.
    function automatic logic [31:0] quad_step(input logic [1:0] now_p,
                                              input logic [1:0] prev_p);
        logic [1:0] diff;
        diff = {now_p[1], now_p[1] ^ now_p[0]} - {prev_p[1], prev_p[1] ^ prev_p[0]};
        if (diff == 2'd1) return 32'd1;
        if (diff == 2'd3) return 32'hFFFF_FFFF;
        return 32'd0;
    endfunction

    function automatic logic [31:0] angle_of(input logic [31:0] cnt);
        logic        neg;
        logic [63:0] prod;
        neg  = cnt[31];
        prod = {32'd0, neg ? 32'd0 - cnt : cnt} * {32'd0, cur_scale};
        return clamp32(neg, (prod + 64'd32768) >> 16);
    endfunction

    // delta * scale * 1e6 / dt, Q16.16; 1e6/65536 = 15625/1024
    function automatic logic [31:0] rate_of(input logic [31:0] delta, input logic [31:0] dt);
        logic         neg;
        logic [63:0]  prod;
        logic [127:0] num;
        logic [127:0] quo;
        neg  = delta[31];
        prod = {32'd0, neg ? 32'd0 - delta : delta} * {32'd0, cur_scale};
        num  = {64'd0, prod} * 128'd15625 + {96'd0, dt} * 128'd512;
        quo  = num / {96'd0, dt};
        if (quo[127:64] != '0) return clamp32(neg, '1);
        return clamp32(neg, quo[63:0] >> 10);
    endfunction

    function automatic logic [31:0] blend_velocity(input logic signed [31:0] fresh,
                                                   input logic signed [31:0] old);
        longint      wa;
        longint      acc;
        logic        neg;
        logic [63:0] mag;
        wa  = (cur_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(cur_alpha);
        acc = wa * longint'(fresh) + (64'sd65536 - wa) * longint'(old);
        neg = acc < 0;
        mag = neg ? 64'(-acc) : 64'(acc);
        return clamp32(neg, (mag + 64'd32768) >> 16);
    endfunction

    function automatic quad_result_t track_encoder(input mode_t md, input logic [1:0] pins,
                                                   input logic [31:0] t_us);
        quad_result_t r;
        logic [31:0]  dt;
        r.upd = 1'b0;
        case (md)
            MODE_PIN: begin
                enc_count     = enc_count + quad_step(pins, enc_prev_pins);
                enc_prev_pins = pins;
            end
            MODE_TICK: begin
                dt = t_us - enc_tick_time;
                if (dt != 0 && enc_tick_time != 0) begin
                    enc_velocity = blend_velocity(rate_of(enc_count - enc_tick_count, dt),
                                                  enc_velocity);
                    r.upd = 1'b1;
                end
                enc_tick_count = enc_count;
                enc_tick_time  = t_us;
            end
            MODE_START: begin
                enc_prev_pins  = pins;
                enc_count      = '0;
                enc_tick_count = '0;
                enc_tick_time  = t_us;
            end
            default: ;
        endcase
        r.count = enc_count;
        r.angle = angle_of(enc_count);
        r.vel   = enc_velocity;
        return r;
    endfunction

    // ------------------------------------------------------------- drivers

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // output side; a hold request blocks m_tready for a counted stretch
    initial begin
        int hold_seen;
        int hold_cnt;
        hold_seen = 0;
        hold_cnt  = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_cnt  = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_item(input mode_t md, input logic [1:0] pins, input logic [31:0] t_us,
                             input logic typed, input quad_result_t want);
        quad_result_t pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {6'd0, t_us, pins[0], pins[1]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = track_encoder(md, pins, t_us);
        pending_results.push_back(typed ? want : pred);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] val);
        drain_results();
        repeat (8) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (sel == CFG_SCALE) begin
            cur_scale = val;
        end else begin
            cur_alpha = val[16:0];
        end
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly clean quadrature walks with ticks; some noise, starts and idle mode
    task automatic random_segment(input int n, input int seg);
        int          roll;
        int          sub;
        logic [1:0]  dir;
        logic [1:0]  phase;
        logic [1:0]  pins;
        logic [31:0] dt;
        dir = 2'd1;
        for (int i = 0; i < n; i++) begin
            if (seg == 0 && i == 40) hold_reqs++;
            if (seg == 3 && i == 60) hold_reqs++;
            if (seg == 1 && i == n / 2) drain_results();
            roll = $urandom_range(99);
            sub  = $urandom_range(99);
            if (roll < 70) begin
                phase = {enc_prev_pins[1], enc_prev_pins[1] ^ enc_prev_pins[0]};
                if (sub < 10) dir = 2'd0 - dir;
                if (sub < 85) phase = phase + dir;
                pins = {phase[1], phase[1] ^ phase[0]};
                if (sub >= 92) pins = 2'($urandom_range(3));
                send_item(MODE_PIN, pins, $urandom, 1'b0, NOT_TYPED);
            end else if (roll < 90) begin
                if (sub < 5) begin
                    dt = '0;
                end else if (sub < 65) begin
                    dt = $urandom_range(2000, 1);
                end else if (sub < 90) begin
                    dt = $urandom_range(1000000, 2001);
                end else begin
                    dt = $urandom;
                end
                clock_us = clock_us + dt;
                send_item(MODE_TICK, 2'($urandom_range(3)), clock_us, 1'b0, NOT_TYPED);
            end else if (roll < 95) begin
                clock_us = ($urandom_range(4) == 0) ? 32'd0 : $urandom;
                send_item(MODE_START, 2'($urandom_range(3)), clock_us, 1'b0, NOT_TYPED);
            end else begin
                send_item(MODE_NONE, 2'($urandom_range(3)), $urandom, 1'b0, NOT_TYPED);
            end
        end
    endtask

    // -------------------------------------------------------------- checker

    always @(posedge aclk) begin
        quad_result_t got;
        quad_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("tb_top: unexpected result beat cnt=%h ang=%h vel=%h upd=%b",
                             got.count, got.angle, got.vel, got.upd);
                end
            end else begin
                want = pending_results.pop_front();
                beats_checked++;
                if (want.upd) vel_updates++;
                if (got.count !== want.count || got.angle !== want.angle ||
                    got.vel !== want.vel || got.upd !== want.upd) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("tb_top: mismatch at result %0d", beats_checked);
                        $display("  expected cnt=%h ang=%h vel=%h upd=%b",
                                 want.count, want.angle, want.vel, want.upd);
                        $display("  actual   cnt=%h ang=%h vel=%h upd=%b",
                                 got.count, got.angle, got.vel, got.upd);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------ sequence

    initial begin
        logic [31:0] alpha_word;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                write_reg(directed_rows[k].reg_sel, directed_rows[k].value);
            end else begin
                send_item(directed_rows[k].md, directed_rows[k].pins,
                          directed_rows[k].value, directed_rows[k].typed,
                          directed_rows[k].want);
            end
        end

        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin tx_idle_pct = 22; rx_idle_pct = 63; end
                1: begin tx_idle_pct = 63; rx_idle_pct = 22; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            // upper data bits above the alpha field are don't-care
            alpha_word = {15'($urandom), 17'($urandom_range(131071))};
            case (seg)
                0: begin
                    write_reg(CFG_SCALE, SCALE_RESET);
                    write_reg(CFG_ALPHA, 32'(ALPHA_RESET));
                end
                1: begin write_reg(CFG_SCALE, '1); write_reg(CFG_ALPHA, 32'(ALPHA_ONE)); end
                2: begin write_reg(CFG_SCALE, 32'd1);       write_reg(CFG_ALPHA, 32'd0);       end
                3: begin write_reg(CFG_SCALE, $urandom);    write_reg(CFG_ALPHA, alpha_word);  end
                4: begin
                    write_reg(CFG_SCALE, $urandom_range(100000000, 1000));
                    write_reg(CFG_ALPHA, $urandom_range(65536));
                end
                default: begin write_reg(CFG_SCALE, $urandom); write_reg(CFG_ALPHA, 32'h1FFFF); end
            endcase
            random_segment(SEG_BEATS, seg);
        end

        drain_results();
        repeat (60) @(posedge aclk);
        if (pending_results.size() != 0) errors++;

        $display("tb_top: %0d beats sent, %0d results checked, %0d velocity updates, %0d writes",
                 beats_sent, beats_checked, vel_updates, reg_writes);
        $display("tb_top: walks, double-bit flips, tick/start timing cases, saturation, %s",
                 "alpha clamp and long output stalls");
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: %0d mismatches", errors);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
